// File: rtl/core/tcgb_pkg.sv
// ----------------------------------------------------------------------------
// Text console glyph blitter package
// Field widths, font store geometry, cursor limits and command codes shared by
// the channel interfaces and the blitter itself.
// ----------------------------------------------------------------------------
package tcgb_pkg;

  // Font store geometry: GLYPH_COUNT glyphs of GLYPH_ROWS rows, one byte a row.
  // Both are powers of two, so a glyph starts at its code shifted left by the
  // row address width, and its rows follow on from there.
  localparam int unsigned GLYPH_ROWS   = 16;
  localparam int unsigned GLYPH_COUNT  = 256;
  localparam int unsigned FONT_DEPTH   = GLYPH_ROWS * GLYPH_COUNT;
  localparam int unsigned FONT_AW      = $clog2(FONT_DEPTH);
  localparam int unsigned ROW_W        = $clog2(GLYPH_ROWS);

  // Every drawn or erased character produces this many row writes.
  localparam int unsigned ROWS_OUT     = 16;
  localparam int unsigned ROWS_OUT_W   = $clog2(ROWS_OUT);

  // Field widths.
  localparam int unsigned FUNC_W       = 2;
  localparam int unsigned CODE_W       = 8;
  localparam int unsigned ROWIDX_W     = 4;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned OFFSET_W     = 26;
  localparam int unsigned MASK_W       = 8;
  localparam int unsigned COLOUR_W     = 32;
  localparam int unsigned CURX_W       = 13;
  localparam int unsigned CURY_W       = 12;
  localparam int unsigned SWIDTH_W     = 13;
  localparam int unsigned PITCH_W      = 14;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 32;

  // Character cell and cursor limits.
  localparam logic [CURX_W-1:0]   CELL_W     = CURX_W'(8);
  localparam logic [CURY_W-1:0]   LINE_H     = CURY_W'(16);
  localparam logic [CURY_W-1:0]   Y_MAX      = CURY_W'(4080);
  localparam logic [MASK_W-1:0]   FULL_MASK  = '1;

  // Register reset values.
  localparam logic [COLOUR_W-1:0] INK_RST    = 32'hFFFF_FFFF;
  localparam logic [COLOUR_W-1:0] ERASE_RST  = '0;
  localparam logic [SWIDTH_W-1:0] SWIDTH_RST = SWIDTH_W'(640);
  localparam logic [PITCH_W-1:0]  PITCH_RST  = PITCH_W'(640);

  // Command codes carried in the func field.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_ROW = 2'd0,
    FUNC_PUT_CHAR = 2'd1,
    FUNC_NEW_LINE = 2'd2,
    FUNC_ERASE    = 2'd3
  } func_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INK_COLOUR   = 2'd0,
    REG_ERASE_COLOUR = 2'd1,
    REG_SCREEN_WIDTH = 2'd2,
    REG_LINE_PITCH   = 2'd3
  } cfg_reg_t;

endpackage

// File: rtl/core/tcgb_in_if.sv
// ----------------------------------------------------------------------------
// Text console glyph blitter command channel
// Valid/ready channel that carries one console command request.
// ----------------------------------------------------------------------------
interface tcgb_in_if;
  logic                              valid;
  logic                              ready;
  logic [tcgb_pkg::FUNC_W-1:0]       func;
  logic [tcgb_pkg::CODE_W-1:0]       char_code;
  logic [tcgb_pkg::ROWIDX_W-1:0]     row_index;
  logic [tcgb_pkg::BYTE_W-1:0]       font_byte;

  modport source (output valid, func, char_code, row_index, font_byte, input ready);
  modport sink   (input valid, func, char_code, row_index, font_byte, output ready);
endinterface

// File: rtl/core/tcgb_out_if.sv
// ----------------------------------------------------------------------------
// Text console glyph blitter row write channel
// Valid/ready channel that carries one masked eight-pixel row write request.
// ----------------------------------------------------------------------------
interface tcgb_out_if;
  logic                              valid;
  logic                              ready;
  logic [tcgb_pkg::OFFSET_W-1:0]     pixel_offset;
  logic [tcgb_pkg::MASK_W-1:0]       pixel_mask;
  logic [tcgb_pkg::COLOUR_W-1:0]     pixel_value;
  logic                              last_row;

  modport source (output valid, pixel_offset, pixel_mask, pixel_value, last_row,
                  input ready);
  modport sink   (input valid, pixel_offset, pixel_mask, pixel_value, last_row,
                  output ready);
endinterface

// File: rtl/core/tcgb_cfg_if.sv
// ----------------------------------------------------------------------------
// Text console glyph blitter configuration channel
// Valid/ready write channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface tcgb_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tcgb_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [tcgb_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

// File: rtl/core/text_console_glyph_blitter_unit.sv
// ----------------------------------------------------------------------------
// Text console glyph blitter
// Turns console commands into masked eight-pixel row writes for a 32-bit
// framebuffer, using an on-chip 8x16 bitmap font store and a text cursor.
// ----------------------------------------------------------------------------
// Loading a font row and starting a new line finish as the request is taken and
// produce nothing. Drawing or erasing a character produces sixteen row write
// requests, one per cycle when the sink keeps ready high: taking the request
// starts the first font read, and then the single read port of the font store
// delivers one glyph row for each request. The command channel is ready only
// while no character is in progress. The font store powers up with undefined
// contents; drawing a glyph row that was never loaded yields an undefined mask.
// Configuration writes are accepted in every cycle and are meant to be made
// while the block is idle.
module text_console_glyph_blitter_unit (
  input  logic        clk,
  input  logic        rst_n,
  tcgb_in_if.sink     in_if,
  tcgb_out_if.source  out_if,
  tcgb_cfg_if.sink    cfg_if
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  localparam int unsigned ROWS_OUT_W_L = tcgb_pkg::ROWS_OUT_W;
  localparam logic [ROWS_OUT_W_L-1:0] LAST_K = ROWS_OUT_W_L'(tcgb_pkg::ROWS_OUT - 1);

  // Control and configuration state.
  state_t                               state_r, state_nxt;
  logic [tcgb_pkg::CURX_W-1:0]          cur_x_r, cur_x_nxt;
  logic [tcgb_pkg::CURY_W-1:0]          cur_y_r, cur_y_nxt;
  logic [tcgb_pkg::COLOUR_W-1:0]        ink_r;
  logic [tcgb_pkg::COLOUR_W-1:0]        erase_r;
  logic [tcgb_pkg::SWIDTH_W-1:0]        swidth_r;
  logic [tcgb_pkg::PITCH_W-1:0]         pitch_r;
  logic                                 out_valid_r, out_valid_nxt;

  // Per-character working registers.
  logic                                 is_put_r;
  logic [tcgb_pkg::CODE_W-1:0]          code_r;
  logic [ROWS_OUT_W_L-1:0]              k_r, k_nxt;
  logic [tcgb_pkg::OFFSET_W-1:0]        off_r;

  // Output payload registers.
  logic [tcgb_pkg::OFFSET_W-1:0]        out_off_r;
  logic [tcgb_pkg::MASK_W-1:0]          out_mask_r;
  logic [tcgb_pkg::COLOUR_W-1:0]        out_value_r;
  logic                                 out_last_r;

  // Font store with a registered read port.
  logic [tcgb_pkg::BYTE_W-1:0]          font_mem [tcgb_pkg::FONT_DEPTH];
  logic [tcgb_pkg::BYTE_W-1:0]          font_q;
  logic [tcgb_pkg::FONT_AW-1:0]         rd_addr;
  logic [tcgb_pkg::FONT_AW-1:0]         wr_addr;
  logic                                 wr_en;

  logic                                 in_take;
  logic                                 row_take;
  tcgb_pkg::func_t                      func;

  // Cursor arithmetic for the incoming command.
  logic [tcgb_pkg::CURX_W-1:0]          put_x_step;
  logic [tcgb_pkg::CURX_W-1:0]          put_x;
  logic [tcgb_pkg::CURY_W-1:0]          put_y;
  logic [tcgb_pkg::CURX_W-1:0]          er_x0;
  logic [tcgb_pkg::CURY_W-1:0]          er_y0;
  logic [tcgb_pkg::CURX_W-1:0]          er_start;
  logic [tcgb_pkg::CURX_W-1:0]          er_x;
  logic [tcgb_pkg::CURY_W-1:0]          er_y;
  logic [tcgb_pkg::CURX_W-1:0]          draw_x;
  logic [tcgb_pkg::CURY_W-1:0]          draw_y;
  logic [tcgb_pkg::OFFSET_W-1:0]        first_off;

  function automatic logic [tcgb_pkg::CURY_W-1:0] line_down(
    input logic [tcgb_pkg::CURY_W-1:0] y
  );
    logic [tcgb_pkg::CURY_W:0] sum;
    sum = {1'b0, y} + {1'b0, tcgb_pkg::LINE_H};
    return (sum > {1'b0, tcgb_pkg::Y_MAX}) ? tcgb_pkg::Y_MAX : sum[tcgb_pkg::CURY_W-1:0];
  endfunction

  function automatic logic [tcgb_pkg::CURY_W-1:0] line_up(
    input logic [tcgb_pkg::CURY_W-1:0] y
  );
    return (y >= tcgb_pkg::LINE_H) ? y - tcgb_pkg::LINE_H : '0;
  endfunction

  assign func     = tcgb_pkg::func_t'(in_if.func);
  assign in_if.ready = (state_r == ST_IDLE);
  assign in_take  = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  // A row leaves the working stage whenever the output register is free or
  // is being emptied in this cycle.
  assign row_take = (state_r == ST_RUN) && (!out_valid_r || out_if.ready);

  // Drawing moves the cursor one cell right and wraps to the next text line
  // when the following cell would not fit on the screen.
  always_comb begin
    put_x_step = tcgb_pkg::CURX_W'(cur_x_r + tcgb_pkg::CELL_W);
    if (({1'b0, put_x_step} + {1'b0, tcgb_pkg::CELL_W}) > {1'b0, swidth_r}) begin
      put_x = '0;
      put_y = line_down(cur_y_r);
    end else begin
      put_x = put_x_step;
      put_y = cur_y_r;
    end
  end

  // Erasing first steps back to the end of the previous line if the cursor
  // sits at the left margin; the cell erased is the one left of that point,
  // or the leftmost cell when less than one cell remains.
  always_comb begin
    if (cur_x_r == '0) begin
      er_x0 = swidth_r;
      er_y0 = line_up(cur_y_r);
    end else begin
      er_x0 = cur_x_r;
      er_y0 = cur_y_r;
    end
    er_start = (er_x0 >= tcgb_pkg::CELL_W) ? er_x0 - tcgb_pkg::CELL_W : '0;
    if (er_x0 < tcgb_pkg::CELL_W) begin
      er_x = swidth_r;
      er_y = line_up(er_y0);
    end else begin
      er_x = er_x0 - tcgb_pkg::CELL_W;
      er_y = er_y0;
    end
  end

  // Position of the first row: one multiply, then each further row adds the
  // line pitch, which gives the same result modulo the offset width.
  always_comb begin
    if (func == tcgb_pkg::FUNC_PUT_CHAR) begin
      draw_x = cur_x_r;
      draw_y = cur_y_r;
    end else begin
      draw_x = er_start;
      draw_y = er_y0;
    end
    first_off = tcgb_pkg::OFFSET_W'(draw_y * pitch_r)
              + tcgb_pkg::OFFSET_W'(draw_x);
  end

  // Sequencing, cursor updates and the row counter.
  always_comb begin
    state_nxt     = state_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          case (func)
            tcgb_pkg::FUNC_LOAD_ROW: begin
            end
            tcgb_pkg::FUNC_PUT_CHAR: begin
              cur_x_nxt = put_x;
              cur_y_nxt = put_y;
              k_nxt     = '0;
              state_nxt = ST_RUN;
            end
            tcgb_pkg::FUNC_NEW_LINE: begin
              cur_x_nxt = '0;
              cur_y_nxt = line_down(cur_y_r);
            end
            tcgb_pkg::FUNC_ERASE: begin
              cur_x_nxt = er_x;
              cur_y_nxt = er_y;
              k_nxt     = '0;
              state_nxt = ST_RUN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        if (row_take) begin
          out_valid_nxt = 1'b1;
          k_nxt         = k_r + 1'b1;
          if (k_r == LAST_K) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The read address always points at the row that the working stage will
  // hand on next, so the registered read data is ready for it; while the
  // output stalls the same row is read again. Row addresses wrap at the
  // store depth.
  always_comb begin
    if (state_r == ST_IDLE) begin
      rd_addr = tcgb_pkg::FONT_AW'({in_if.char_code, tcgb_pkg::ROW_W'(0)});
    end else begin
      rd_addr = tcgb_pkg::FONT_AW'({code_r, tcgb_pkg::ROW_W'(0)})
              + tcgb_pkg::FONT_AW'(k_nxt);
    end
    wr_addr = tcgb_pkg::FONT_AW'({in_if.char_code, tcgb_pkg::ROW_W'(0)})
            + tcgb_pkg::FONT_AW'(in_if.row_index);
    wr_en   = in_take && (func == tcgb_pkg::FUNC_LOAD_ROW);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      font_mem[wr_addr] <= in_if.font_byte;
    end
    font_q <= font_mem[rd_addr];
  end

  // Control state, configuration registers and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      ink_r       <= tcgb_pkg::INK_RST;
      erase_r     <= tcgb_pkg::ERASE_RST;
      swidth_r    <= tcgb_pkg::SWIDTH_RST;
      pitch_r     <= tcgb_pkg::PITCH_RST;
    end else begin
      state_r     <= state_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        case (tcgb_pkg::cfg_reg_t'(cfg_if.reg_index))
          tcgb_pkg::REG_INK_COLOUR:   ink_r    <= cfg_if.data;
          tcgb_pkg::REG_ERASE_COLOUR: erase_r  <= cfg_if.data;
          tcgb_pkg::REG_SCREEN_WIDTH: swidth_r <= cfg_if.data[tcgb_pkg::SWIDTH_W-1:0];
          tcgb_pkg::REG_LINE_PITCH:   pitch_r  <= cfg_if.data[tcgb_pkg::PITCH_W-1:0];
          default: begin
          end
        endcase
      end
    end

    if (in_take) begin
      is_put_r <= (func == tcgb_pkg::FUNC_PUT_CHAR);
      code_r   <= in_if.char_code;
      off_r    <= first_off;
    end else if (row_take) begin
      off_r    <= off_r + tcgb_pkg::OFFSET_W'(pitch_r);
    end

    if (row_take) begin
      out_off_r   <= off_r;
      out_mask_r  <= is_put_r ? font_q : tcgb_pkg::FULL_MASK;
      out_value_r <= is_put_r ? ink_r : erase_r;
      out_last_r  <= (k_r == LAST_K);
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.pixel_offset = out_off_r;
  assign out_if.pixel_mask   = out_mask_r;
  assign out_if.pixel_value  = out_value_r;
  assign out_if.last_row     = out_last_r;

endmodule
